// ----- hdl/imh_pkg.sv -----
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and constants for the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

	localparam int KEY_W        = 64;
	localparam int HANDLE_W     = 10;
	localparam int COUNT_W      = 11;
	localparam int CAPACITY_DEF = 1024;
	localparam int HANDLES_DEF  = 1024;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_GET_MIN = 2'd1,
		CMD_EXTRACT = 2'd2,
		CMD_DECREASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_HANDLE = 2'd3
	} status_t;

endpackage

// ----- hdl/imh_ram.sv -----
// ----------------------------------------------------------------------------
// imh_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/indexed_min_heap.sv -----
// One transaction in flight: get_min answers from the tracked root, insert sifts
// up, decrease-key sifts up and then down, and extract sifts down (each level
// reads both children). A stalled response holds the block in its final state.
// After reset the handle table is cleared, one entry per cycle.
// ----------------------------------------------------------------------------
// indexed_min_heap
// Binary min-heap of signed keys with a handle-to-slot table for decrease-key.
// ----------------------------------------------------------------------------
module indexed_min_heap #(
	parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
	parameter int HANDLES  = imh_pkg::HANDLES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   command,
	input  logic [imh_pkg::HANDLE_W-1:0] handle,
	input  logic [imh_pkg::KEY_W-1:0]    value,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [1:0]                   status,
	output logic [imh_pkg::KEY_W-1:0]    min_key,
	output logic [imh_pkg::COUNT_W-1:0]  entry_count
);
	import imh_pkg::*;

	localparam int SW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int HW    = (HANDLES > 1) ? $clog2(HANDLES) : 1;
	localparam int ENT_W = KEY_W + HW;
	localparam int IW    = SW + 2;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_HCHK, S_EXT_LD, S_DK_LD,
		S_UP, S_UP_CMP, S_DN, S_DN_R, S_DN_CMP, S_FIN
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [HANDLE_W-1:0] hnd_q;
	logic [KEY_W-1:0]    val_q;
	logic                dk_q;
	logic [KEY_W-1:0]    cur_key_q;
	logic [HW-1:0]       cur_hnd_q;
	logic [SW-1:0]       pos_q;
	logic [CW-1:0]       cnt_q;
	logic [KEY_W-1:0]    root_key_q;
	logic [HW-1:0]       root_hnd_q;
	logic [ENT_W-1:0]    lft_q;
	logic                has_r_q;
	logic [HW-1:0]       clr_q;
	status_t             stat_q;
	logic                rsp_valid_q;
	logic [1:0]          status_q;
	logic [KEY_W-1:0]    min_key_q;
	logic [COUNT_W-1:0]  entry_count_q;

	logic             h_we;
	logic [SW-1:0]    h_waddr, h_raddr;
	logic [ENT_W-1:0] h_wdata, h_rdata;
	logic             s_we;
	logic [HW-1:0]    s_waddr, s_raddr;
	logic [SW:0]      s_wdata, s_rdata;

	imh_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_heap_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	imh_ram #(.WIDTH(SW + 1), .DEPTH(HANDLES)) u_slot_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	// derived values
	logic             q_bad_range, s_valid, up_less, bl, br, ovf, slot_ok;
	logic [SW-1:0]    s_slot, parent;
	logic [IW-1:0]    lidx, ridx, cnt_ext;
	logic [KEY_W-1:0] rd_key, lk, best_key, diff, sat_key;
	logic [HW-1:0]    rd_hnd;

	assign q_bad_range = 32'(hnd_q) >= HANDLES;
	assign s_valid     = s_rdata[SW];
	assign s_slot      = s_rdata[SW-1:0];
	assign cnt_ext     = IW'(cnt_q);
	assign slot_ok     = IW'(s_slot) < cnt_ext;
	assign parent      = (pos_q - 1'b1) >> 1;
	assign lidx        = (IW'(pos_q) << 1) + IW'(1);
	assign ridx        = lidx + IW'(1);
	assign rd_key      = h_rdata[ENT_W-1:HW];
	assign rd_hnd      = h_rdata[HW-1:0];
	assign lk          = lft_q[ENT_W-1:HW];
	assign up_less     = $signed(cur_key_q) < $signed(rd_key);
	assign bl          = $signed(lk) < $signed(cur_key_q);
	assign best_key    = bl ? lk : cur_key_q;
	assign br          = has_r_q && ($signed(rd_key) < $signed(best_key));
	assign diff        = rd_key - val_q;
	assign ovf         = (rd_key[KEY_W-1] ^ val_q[KEY_W-1]) & (rd_key[KEY_W-1] ^ diff[KEY_W-1]);
	assign sat_key     = !ovf ? diff :
	                     (val_q[KEY_W-1] ? {1'b0, {(KEY_W-1){1'b1}}}
	                                     : {1'b1, {(KEY_W-1){1'b0}}});

	// drive memory ports
	always_comb begin
		h_we    = 1'b0;
		h_waddr = pos_q;
		h_wdata = {cur_key_q, cur_hnd_q};
		h_raddr = '0;
		s_we    = 1'b0;
		s_waddr = cur_hnd_q;
		s_wdata = {1'b1, pos_q};
		s_raddr = '0;
		unique case (state_q)
			S_CLR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = '0;
			end
			S_IDLE: begin
				s_raddr = HW'(handle);
				if (req_valid && cmd_t'(command) == CMD_EXTRACT && cnt_q != '0) begin
					s_we    = 1'b1;
					s_waddr = root_hnd_q;
					s_wdata = '0;
					h_raddr = SW'(cnt_q - 1'b1);
				end
			end
			S_HCHK: begin
				h_raddr = s_slot;
			end
			S_UP: begin
				if (pos_q != '0) begin
					h_raddr = parent;
				end else if (!dk_q) begin
					h_we = 1'b1;
					s_we = 1'b1;
				end
			end
			S_UP_CMP: begin
				if (up_less) begin
					h_we    = 1'b1;
					h_wdata = h_rdata;
					s_we    = 1'b1;
					s_waddr = rd_hnd;
				end else if (!dk_q) begin
					h_we = 1'b1;
					s_we = 1'b1;
				end
			end
			S_DN: begin
				if (lidx >= cnt_ext) begin
					h_we = 1'b1;
					s_we = 1'b1;
				end else begin
					h_raddr = SW'(lidx);
				end
			end
			S_DN_R: begin
				h_raddr = SW'(ridx);
			end
			S_DN_CMP: begin
				h_we = 1'b1;
				s_we = 1'b1;
				if (br) begin
					h_wdata = h_rdata;
					s_waddr = rd_hnd;
				end else if (bl) begin
					h_wdata = lft_q;
					s_waddr = lft_q[HW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// track the root entry as it is written
	always_ff @(posedge clk) begin
		if (h_we && h_waddr == '0) begin
			root_key_q <= h_wdata[ENT_W-1:HW];
			root_hnd_q <= h_wdata[HW-1:0];
		end
	end

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HW'(HANDLES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q  <= cmd_t'(command);
						hnd_q  <= handle;
						val_q  <= value;
						stat_q <= ST_OK;
						pos_q  <= '0;
						dk_q   <= 1'b0;
						unique case (cmd_t'(command))
							CMD_INSERT, CMD_DECREASE: state_q <= S_HCHK;
							CMD_GET_MIN: begin
								if (cnt_q == '0) stat_q <= ST_EMPTY;
								state_q <= S_FIN;
							end
							CMD_EXTRACT: begin
								if (cnt_q == '0) begin
									stat_q  <= ST_EMPTY;
									state_q <= S_FIN;
								end else begin
									cnt_q   <= cnt_q - 1'b1;
									state_q <= (cnt_q == CW'(1)) ? S_FIN : S_EXT_LD;
								end
							end
						endcase
					end
				end
				S_HCHK: begin
					if (cmd_q == CMD_INSERT) begin
						priority if (q_bad_range || s_valid) begin
							stat_q  <= ST_HANDLE;
							state_q <= S_FIN;
						end else if (cnt_q >= CW'(CAPACITY)) begin
							stat_q  <= ST_FULL;
							state_q <= S_FIN;
						end else begin
							cur_key_q <= val_q;
							cur_hnd_q <= HW'(hnd_q);
							pos_q     <= SW'(cnt_q);
							cnt_q     <= cnt_q + 1'b1;
							state_q   <= S_UP;
						end
					end else begin
						if (q_bad_range || !s_valid || !slot_ok) begin
							stat_q  <= ST_HANDLE;
							state_q <= S_FIN;
						end else begin
							pos_q   <= s_slot;
							state_q <= S_DK_LD;
						end
					end
				end
				S_EXT_LD: begin
					cur_key_q <= rd_key;
					cur_hnd_q <= rd_hnd;
					state_q   <= S_DN;
				end
				S_DK_LD: begin
					cur_key_q <= sat_key;
					cur_hnd_q <= rd_hnd;
					dk_q      <= 1'b1;
					state_q   <= S_UP;
				end
				S_UP: begin
					if (pos_q != '0) state_q <= S_UP_CMP;
					else state_q <= dk_q ? S_DN : S_FIN;
				end
				S_UP_CMP: begin
					if (up_less) begin
						pos_q   <= parent;
						state_q <= S_UP;
					end else begin
						state_q <= dk_q ? S_DN : S_FIN;
					end
				end
				S_DN: begin
					state_q <= (lidx >= cnt_ext) ? S_FIN : S_DN_R;
				end
				S_DN_R: begin
					lft_q   <= h_rdata;
					has_r_q <= ridx < cnt_ext;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					priority if (br) begin
						pos_q   <= SW'(ridx);
						state_q <= S_DN;
					end else if (bl) begin
						pos_q   <= SW'(lidx);
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q   <= 1'b1;
						status_q      <= stat_q;
						min_key_q     <= (cnt_q != '0) ? root_key_q : '0;
						entry_count_q <= COUNT_W'(cnt_q);
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall   = state_q != S_IDLE;
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign min_key     = min_key_q;
	assign entry_count = entry_count_q;

endmodule
